[sv/czh_pkg.sv]
// shared types, constants and helpers of the click zone hit test unit
package czh_pkg;

  localparam int COORD_BITS = 12;
  // multiplier operand: holds a squared difference times four
  localparam int MUL_W = 2 * COORD_BITS + 4;
  // accumulator: sum of two products of squares plus one more term
  localparam int ACC_W = 4 * COORD_BITS + 2;
  localparam int RADIUS_BITS = 8;
  localparam int CFG_IDX_W = 1;
  localparam int STEP_W = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   diff_t;
  typedef logic signed [MUL_W-1:0]      mul_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic [RADIUS_BITS-1:0]       radius_t;

  // corner point of the crossing ray
  localparam diff_t RAY_ORIGIN = diff_t'(-19);

  localparam radius_t HIT_RADIUS_RST  = radius_t'(4);
  localparam radius_t NEAR_RADIUS_RST = radius_t'(7);

  localparam logic [CFG_IDX_W-1:0] REG_HIT_RADIUS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_RADIUS = 1'b1;

  localparam logic [2:0] OP_VERTEX  = 3'd0;
  localparam logic [2:0] OP_POINT   = 3'd1;
  localparam logic [2:0] OP_RECT    = 3'd2;
  localparam logic [2:0] OP_CIRCLE  = 3'd3;
  localparam logic [2:0] OP_ELLIPSE = 3'd4;

  localparam logic [1:0] ST_OUTSIDE = 2'd0;
  localparam logic [1:0] ST_INSIDE  = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  localparam int EDGE_STEPS    = 8;
  localparam int CIRCLE_STEPS  = 3;
  localparam int ELLIPSE_STEPS = 7;
  localparam int POINT_STEPS   = 6;

  // control that travels with one product through the multiply-accumulate unit
  typedef struct packed {
    logic       first;
    logic       last;
    logic       sub;
    logic [1:0] dest;
  } mac_ctl_t;

  function automatic mul_t sx(diff_t v);
    return mul_t'(v);
  endfunction

endpackage

[sv/click_zone_hit_test_unit.sv]
// click zone hit test: rectangle, circle, ellipse, polygon and point-list tests
//
//   channel  signals                         direction
//   in       in_valid / in_stall + fields    item in
//   out      out_valid / out_stall + fields  result out
//   cfg      cfg_write, cfg_index, cfg_data  register write
//
// rectangles, bad shapes and runs already decided load the output register at the
// accepting edge; a polygon's first vertex is only stored, and other items run products
// through the one multiply-accumulate unit (the closing vertex also runs the closing edge).
// rst is synchronous and restores the radii and closes any open run.
// a result held under out_stall blocks the next transaction, and a computed result
// waits in place until the output register is free.
module click_zone_hit_test_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [2:0]                       opcode,
  input  czh_pkg::coord_t                  click_x,
  input  czh_pkg::coord_t                  click_y,
  input  czh_pkg::coord_t                  coord_a,
  input  czh_pkg::coord_t                  coord_b,
  input  czh_pkg::coord_t                  coord_c,
  input  czh_pkg::coord_t                  coord_d,
  input  logic                             last_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic                             near_hit,
  input  logic                             cfg_write,
  input  logic [czh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  czh_pkg::radius_t                 cfg_data
);
  import czh_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_RUN, S_DRAIN, S_EVAL, S_FIN} state_t;
  typedef enum logic [1:0] {K_EDGE, K_CIRCLE, K_ELLIPSE, K_POINT} kind_t;

  state_t state;
  kind_t  job_kind;
  logic [STEP_W-1:0] step;
  logic   job_emit, job_second;
  logic [1:0] pend_status;
  logic   pend_near;

  radius_t hit_radius, near_radius;
  logic   run_open, run_kind, crossing_parity, point_found, point_near;
  coord_t held_click_x, held_click_y;
  coord_t first_vertex_x, first_vertex_y, prev_vertex_x, prev_vertex_y;
  logic [1:0] vertex_count;

  coord_t jcx, jcy, ja, jb, jc, jd;

  // per-transaction decode
  logic   accept, kind_pt, new_run, eff_found, eff_near;
  logic [1:0] eff_count, cnt_inc;
  coord_t eff_cx, eff_cy;
  coord_t xlo, xhi, ylo, yhi;
  logic   rect_in;

  // operand selection
  diff_t  u1, u2, v1, v2, v3, v4, edx, edy, w1, w2, w3, w4, dx, dy;
  mul_t   opa, opb;
  mac_ctl_t ctl;
  logic   issue, last_step;
  acc_t   sums [4];

  logic   le0, le1, edge_hit, par_new;

  assign accept  = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  assign kind_pt   = (opcode == OP_POINT);
  assign new_run   = !run_open || (run_kind != kind_pt);
  assign eff_count = new_run ? 2'd0 : vertex_count;
  assign eff_found = new_run ? 1'b0 : point_found;
  assign eff_near  = new_run ? 1'b0 : point_near;
  assign eff_cx    = new_run ? click_x : held_click_x;
  assign eff_cy    = new_run ? click_y : held_click_y;
  assign cnt_inc   = (eff_count == 2'd3) ? 2'd3 : eff_count + 2'd1;

  assign xlo = (coord_a < coord_c) ? coord_a : coord_c;
  assign xhi = (coord_a < coord_c) ? coord_c : coord_a;
  assign ylo = (coord_b < coord_d) ? coord_b : coord_d;
  assign yhi = (coord_b < coord_d) ? coord_d : coord_b;
  assign rect_in = (click_x >= xlo) && (click_x <= xhi) && (click_y >= ylo) && (click_y <= yhi);

  // crossing test terms as differences against the ray origin or between points, and distance terms
  assign u1  = diff_t'(jcy) - RAY_ORIGIN;
  assign u2  = diff_t'(jcx) - RAY_ORIGIN;
  assign v1  = diff_t'(ja) - RAY_ORIGIN;
  assign v2  = diff_t'(jb) - RAY_ORIGIN;
  assign v3  = diff_t'(jc) - RAY_ORIGIN;
  assign v4  = diff_t'(jd) - RAY_ORIGIN;
  assign edx = diff_t'(jc) - diff_t'(ja);
  assign edy = diff_t'(jd) - diff_t'(jb);
  assign w1  = RAY_ORIGIN - diff_t'(ja);
  assign w2  = RAY_ORIGIN - diff_t'(jb);
  assign w3  = diff_t'(jcx) - diff_t'(ja);
  assign w4  = diff_t'(jcy) - diff_t'(jb);
  assign dx  = diff_t'(ja) - diff_t'(jcx);
  assign dy  = diff_t'(jb) - diff_t'(jcy);

  assign issue = (state == S_RUN);

  always_comb begin
    opa = '0;
    opb = '0;
    ctl = '0;
    last_step = 1'b0;
    unique case (job_kind)
      K_EDGE: begin
        last_step = (step == STEP_W'(EDGE_STEPS - 1));
        unique case (step)
          3'd0: begin opa = sx(u1);  opb = sx(v1); ctl.first = 1'b1; end
          3'd1: begin opa = sx(u2);  opb = sx(v2); ctl.sub = 1'b1; ctl.last = 1'b1;
                      ctl.dest = 2'd0; end
          3'd2: begin opa = sx(u1);  opb = sx(v3); ctl.first = 1'b1; end
          3'd3: begin opa = sx(u2);  opb = sx(v4); ctl.sub = 1'b1; ctl.last = 1'b1;
                      ctl.dest = 2'd1; end
          3'd4: begin opa = sx(edy); opb = sx(w1); ctl.first = 1'b1; end
          3'd5: begin opa = sx(edx); opb = sx(w2); ctl.sub = 1'b1; ctl.last = 1'b1;
                      ctl.dest = 2'd2; end
          3'd6: begin opa = sx(edy); opb = sx(w3); ctl.first = 1'b1; end
          3'd7: begin opa = sx(edx); opb = sx(w4); ctl.sub = 1'b1; ctl.last = 1'b1;
                      ctl.dest = 2'd3; end
          default: ;
        endcase
      end
      K_CIRCLE: begin
        last_step = (step == STEP_W'(CIRCLE_STEPS - 1));
        unique case (step)
          3'd0: begin opa = sx(dx) <<< 2; opb = sx(dx); ctl.first = 1'b1; end
          3'd1: begin opa = sx(dy) <<< 2; opb = sx(dy); end
          3'd2: begin opa = sx(diff_t'(jc)); opb = sx(diff_t'(jc)); ctl.sub = 1'b1;
                      ctl.last = 1'b1; ctl.dest = 2'd0; end
          default: ;
        endcase
      end
      K_ELLIPSE: begin
        last_step = (step == STEP_W'(ELLIPSE_STEPS - 1));
        unique case (step)
          3'd0: begin opa = sx(dx); opb = sx(dx); ctl = '{1'b1, 1'b1, 1'b0, 2'd0}; end
          3'd1: begin opa = sx(dy); opb = sx(dy); ctl = '{1'b1, 1'b1, 1'b0, 2'd1}; end
          3'd2: begin opa = sx(diff_t'(jc)); opb = sx(diff_t'(jc));
                      ctl = '{1'b1, 1'b1, 1'b0, 2'd2}; end
          3'd3: begin opa = sx(diff_t'(jd)); opb = sx(diff_t'(jd));
                      ctl = '{1'b1, 1'b1, 1'b0, 2'd3}; end
          // four times the scaled sum against width squared times height squared
          3'd4: begin opa = $signed({sums[1][MUL_W-3:0], 2'b00});
                      opb = $signed(sums[2][MUL_W-1:0]); ctl.first = 1'b1; end
          3'd5: begin opa = $signed({sums[0][MUL_W-3:0], 2'b00});
                      opb = $signed(sums[3][MUL_W-1:0]); end
          3'd6: begin opa = $signed(sums[2][MUL_W-1:0]);
                      opb = $signed(sums[3][MUL_W-1:0]);
                      ctl.sub = 1'b1; ctl.last = 1'b1; ctl.dest = 2'd0; end
          default: ;
        endcase
      end
      K_POINT: begin
        last_step = (step == STEP_W'(POINT_STEPS - 1));
        unique case (step)
          3'd0: begin opa = sx(dx); opb = sx(dx); ctl.first = 1'b1; end
          3'd1: begin opa = sx(dy); opb = sx(dy); end
          3'd2: begin opa = mul_t'(hit_radius); opb = mul_t'(hit_radius); ctl.sub = 1'b1;
                      ctl.last = 1'b1; ctl.dest = 2'd0; end
          3'd3: begin opa = sx(dx); opb = sx(dx); ctl.first = 1'b1; end
          3'd4: begin opa = sx(dy); opb = sx(dy); end
          3'd5: begin opa = mul_t'(near_radius); opb = mul_t'(near_radius);
                      ctl.sub = 1'b1; ctl.last = 1'b1; ctl.dest = 2'd1; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  czh_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .issue (issue),
    .opa   (opa),
    .opb   (opb),
    .ctl   (ctl),
    .sums  (sums)
  );

  assign le0 = sums[0][ACC_W-1] || (sums[0] == '0);
  assign le1 = sums[1][ACC_W-1] || (sums[1] == '0);

  // edge counts when it crosses the ray line, but never when its start lies on the ray line
  always_comb begin
    logic z1, z2, z3, z4, n1, n2, n3, n4;
    z1 = (sums[0] == '0);
    z2 = (sums[1] == '0);
    z3 = (sums[2] == '0);
    z4 = (sums[3] == '0);
    n1 = sums[0][ACC_W-1];
    n2 = sums[1][ACC_W-1];
    n3 = sums[2][ACC_W-1];
    n4 = sums[3][ACC_W-1];
    edge_hit = !z1 && (z2 || (n1 != n2)) && (z3 || z4 || (n3 != n4));
  end
  assign par_new = crossing_parity ^ edge_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      job_kind        <= K_EDGE;
      step            <= '0;
      job_emit        <= 1'b0;
      job_second      <= 1'b0;
      out_valid       <= 1'b0;
      hit_radius      <= HIT_RADIUS_RST;
      near_radius     <= NEAR_RADIUS_RST;
      run_open        <= 1'b0;
      run_kind        <= 1'b0;
      crossing_parity <= 1'b0;
      point_found     <= 1'b0;
      point_near      <= 1'b0;
      vertex_count    <= 2'd0;
      held_click_x    <= '0;
      held_click_y    <= '0;
      first_vertex_x  <= '0;
      first_vertex_y  <= '0;
      prev_vertex_x   <= '0;
      prev_vertex_y   <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_HIT_RADIUS:  hit_radius  <= cfg_data;
          REG_NEAR_RADIUS: near_radius <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (opcode)
              OP_VERTEX, OP_POINT: begin
                if (new_run) begin
                  run_kind        <= kind_pt;
                  held_click_x    <= click_x;
                  held_click_y    <= click_y;
                  crossing_parity <= 1'b0;
                  vertex_count    <= 2'd0;
                  point_found     <= 1'b0;
                  point_near      <= 1'b0;
                end
                run_open <= !last_item;
                jcx      <= eff_cx;
                jcy      <= eff_cy;
                step     <= '0;
                job_emit <= last_item;
                if (!kind_pt) begin
                  if (eff_count == 2'd0) begin
                    first_vertex_x <= coord_a;
                    first_vertex_y <= coord_b;
                  end
                  prev_vertex_x <= coord_a;
                  prev_vertex_y <= coord_b;
                  vertex_count  <= cnt_inc;
                  ja         <= prev_vertex_x;
                  jb         <= prev_vertex_y;
                  jc         <= coord_a;
                  jd         <= coord_b;
                  job_kind   <= K_EDGE;
                  job_second <= last_item;
                  if (last_item && (cnt_inc != 2'd3)) begin
                    out_valid <= 1'b1;
                    status    <= ST_BAD;
                    near_hit  <= 1'b0;
                  end else if (eff_count != 2'd0) begin
                    state <= S_RUN;
                  end
                end else begin
                  ja       <= coord_a;
                  jb       <= coord_b;
                  job_kind <= K_POINT;
                  if (!eff_found) begin
                    state <= S_RUN;
                  end else if (last_item) begin
                    out_valid <= 1'b1;
                    status    <= ST_INSIDE;
                    near_hit  <= eff_near;
                  end
                end
              end
              OP_RECT: begin
                out_valid <= 1'b1;
                status    <= rect_in ? ST_INSIDE : ST_OUTSIDE;
                near_hit  <= 1'b0;
              end
              OP_CIRCLE, OP_ELLIPSE: begin
                jcx      <= click_x;
                jcy      <= click_y;
                ja       <= coord_a;
                jb       <= coord_b;
                jc       <= coord_c;
                jd       <= coord_d;
                step     <= '0;
                job_emit <= 1'b1;
                job_kind <= (opcode == OP_CIRCLE) ? K_CIRCLE : K_ELLIPSE;
                if ((opcode == OP_CIRCLE) ? coord_c[COORD_BITS-1]
                    : (coord_c[COORD_BITS-1] || coord_c == '0 ||
                       coord_d[COORD_BITS-1] || coord_d == '0)) begin
                  out_valid <= 1'b1;
                  status    <= ST_BAD;
                  near_hit  <= 1'b0;
                end else begin
                  state <= S_RUN;
                end
              end
              default: begin
                out_valid <= 1'b1;
                status    <= ST_BAD;
                near_hit  <= 1'b0;
              end
            endcase
          end
        end
        S_RUN: begin
          step <= step + STEP_W'(1);
          if (last_step) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          pend_near <= 1'b0;
          state     <= job_emit ? S_FIN : S_IDLE;
          unique case (job_kind)
            K_EDGE: begin
              crossing_parity <= par_new;
              pend_status     <= par_new ? ST_INSIDE : ST_OUTSIDE;
              if (job_second) begin
                // closing edge back to the first vertex
                ja         <= jc;
                jb         <= jd;
                jc         <= first_vertex_x;
                jd         <= first_vertex_y;
                job_second <= 1'b0;
                step       <= '0;
                state      <= S_RUN;
              end
            end
            K_POINT: begin
              if (le0) begin
                point_found <= 1'b1;
              end else if (le1) begin
                point_found <= 1'b1;
                point_near  <= 1'b1;
              end
              pend_status <= (le0 || le1) ? ST_INSIDE : ST_OUTSIDE;
              pend_near   <= !le0 && le1;
            end
            K_CIRCLE, K_ELLIPSE: begin
              pend_status <= le0 ? ST_INSIDE : ST_OUTSIDE;
            end
            default: ;
          endcase
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            status    <= pend_status;
            near_hit  <= pend_near;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/czh_mac.sv]
// shared multiply-accumulate unit with four result slots
module czh_mac (
  input  logic             clk,
  input  logic             rst,
  input  logic             issue,
  input  czh_pkg::mul_t    opa,
  input  czh_pkg::mul_t    opb,
  input  czh_pkg::mac_ctl_t ctl,
  output czh_pkg::acc_t    sums [4]
);
  import czh_pkg::*;

  logic signed [2*MUL_W-1:0] full_prod;
  acc_t     prod;
  acc_t     acc;
  acc_t     sum_val;
  mac_ctl_t p_ctl;
  logic     p_vld;

  assign full_prod = opa * opb;

  always_comb begin
    sum_val = (p_ctl.first ? '0 : acc) + (p_ctl.sub ? -prod : prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= issue;
    end
    if (issue) begin
      prod  <= full_prod[ACC_W-1:0];
      p_ctl <= ctl;
    end
    if (p_vld) begin
      acc <= sum_val;
      if (p_ctl.last) begin
        sums[p_ctl.dest] <= sum_val;
      end
    end
  end

endmodule
